// ===== hdl/ir_edge_capture_framer_assert.svh =====
`ifndef IR_EDGE_CAPTURE_FRAMER_ASSERT_SVH
`define IR_EDGE_CAPTURE_FRAMER_ASSERT_SVH

// same-cycle implication
`define IECF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iecf assertion failed");

// next-cycle implication
`define IECF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iecf assertion failed");

`endif

// ===== hdl/iecf_pkg.sv =====
package iecf_pkg;

   localparam int TS_W       = 32;
   localparam int DUR_W      = 32;
   localparam int FREQ_W     = 27;
   localparam int GAP_W      = 16;
   localparam int EDGE_CNT_W = 10;
   localparam int USPS_W     = 20;
   localparam int DVD_W      = TS_W + USPS_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = FREQ_W;

   localparam logic [USPS_W-1:0]     US_PER_S   = USPS_W'(1000000);
   localparam logic [EDGE_CNT_W-1:0] EDGE_LIMIT = EDGE_CNT_W'(500);
   localparam logic [FREQ_W-1:0]     FREQ_RESET = FREQ_W'(1000000);
   localparam logic [GAP_W-1:0]      GAP_RESET  = GAP_W'(150);

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam logic MODE_EDGE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP  = 1'd1;

   typedef enum logic [1:0] {
      CMD_MARK,
      CMD_PAIR,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [TS_W-1:0] delta;
   } cmd_type;

endpackage

// ===== hdl/iecf_if.sv =====
interface iecf_req_if;
   import iecf_pkg::*;

   logic            valid;
   logic            ready;
   logic            mode;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output mode, output timestamp, input ready);
   modport sink   (input valid, input mode, input timestamp, output ready);
endinterface

interface iecf_rsp_if;
   import iecf_pkg::*;

   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] pulse_us;
   logic             is_mark;
   logic             frame_end;
   logic             last;

   modport source (output valid, output pulse_us, output is_mark, output frame_end,
                   output last, input ready);
   modport sink   (input valid, input pulse_us, input is_mark, input frame_end,
                   input last, output ready);
endinterface

// ===== hdl/iecf_cmd_fifo.sv =====
`include "ir_edge_capture_framer_assert.svh"

module iecf_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  iecf_pkg::cmd_type push_data_i,
   output logic              full_o,
   input  logic              pop_i,
   output iecf_pkg::cmd_type head_o,
   output logic              empty_o
);
   import iecf_pkg::*;

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;

   function automatic logic [CMD_PTR_W-1:0] ptr_next(input logic [CMD_PTR_W-1:0] p);
      ptr_next = (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full_o  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   `IECF_ASSERT_IMPL(a_no_overflow, clock, reset, push_i, !full_o || pop_i)
   `IECF_ASSERT_IMPL(a_no_underflow, clock, reset, pop_i, !empty_o)

endmodule

// ===== hdl/iecf_front.sv =====
`include "ir_edge_capture_framer_assert.svh"

module iecf_front (
   input  logic                       clock,
   input  logic                       reset,
   iecf_req_if.sink                   req,
   input  logic [iecf_pkg::GAP_W-1:0] gap_ms_i,
   input  logic                       full_i,
   output logic                       push_o,
   output iecf_pkg::cmd_type          cmd_o
);
   import iecf_pkg::*;

   localparam logic [EDGE_CNT_W-1:0] MIN_EDGES_END = EDGE_CNT_W'(3);

   logic [TS_W-1:0]       prev_ts_ff, prev_ts_in;
   logic [EDGE_CNT_W-1:0] edges_ff, edges_in;
   logic [GAP_W-1:0]      idle_ff, idle_in;
   logic                  open_ff, open_in;
   logic [GAP_W-1:0]      idle_inc;
   logic                  accept;

   assign req.ready = !full_i;
   assign accept    = req.valid && !full_i;

   always_comb begin
      prev_ts_in  = prev_ts_ff;
      edges_in    = edges_ff;
      idle_in     = idle_ff;
      open_in     = open_ff;
      push_o      = 1'b0;
      cmd_o.kind  = CMD_MARK;
      cmd_o.delta = req.timestamp - prev_ts_ff;
      idle_inc    = (idle_ff != '1) ? idle_ff + 1'b1 : idle_ff;
      if (accept) begin
         if (req.mode == MODE_EDGE) begin
            if (edges_ff < EDGE_LIMIT) begin
               if (edges_ff != '0) begin
                  push_o     = 1'b1;
                  // odd edge count: a mark closes; even: its space closes
                  cmd_o.kind = edges_ff[0] ? CMD_MARK : CMD_PAIR;
               end
               prev_ts_in = req.timestamp;
               edges_in   = edges_ff + 1'b1;
            end
            idle_in = '0;
            open_in = 1'b1;
         end else if (open_ff) begin
            idle_in = idle_inc;
            if (idle_inc >= gap_ms_i) begin
               if (edges_ff >= MIN_EDGES_END) begin
                  push_o     = 1'b1;
                  cmd_o.kind = CMD_END;
               end
               edges_in = '0;
               idle_in  = '0;
               open_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ts_ff <= '0;
         edges_ff   <= '0;
         idle_ff    <= '0;
         open_ff    <= 1'b0;
      end else begin
         prev_ts_ff <= prev_ts_in;
         edges_ff   <= edges_in;
         idle_ff    <= idle_in;
         open_ff    <= open_in;
      end
   end

   `IECF_ASSERT_IMPL(a_edge_cap, clock, reset, 1'b1, edges_ff <= EDGE_LIMIT)
   `IECF_ASSERT_IMPL(a_closed_empty, clock, reset, !open_ff, edges_ff == '0 && idle_ff == '0)

endmodule

// ===== hdl/iecf_back.sv =====
`include "ir_edge_capture_framer_assert.svh"

module iecf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [iecf_pkg::FREQ_W-1:0] freq_i,
   input  logic                        cmd_valid_i,
   input  iecf_pkg::cmd_type           cmd_i,
   output logic                        pop_o,
   iecf_rsp_if.source                  rsp
);
   import iecf_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DVD_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT_MARK,
      ST_EMIT_SPACE
   } state_type;

   state_type          state_ff, state_in;
   cmd_kind_type       kind_ff, kind_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [FREQ_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DUR_W-1:0]   mark_ff, mark_in;
   logic [DUR_W-1:0]   space_ff, space_in;
   logic               out_valid_ff, out_valid_in;
   logic [DUR_W-1:0]   out_dur_ff, out_dur_in;
   logic               out_mark_ff, out_mark_in;
   logic               out_end_ff, out_end_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic [FREQ_W:0]    trial;
   logic               take;
   logic [FREQ_W:0]    trial_sub;
   logic [DUR_W-1:0]   quot_sat;

   assign rsp.valid     = out_valid_ff;
   assign rsp.pulse_us  = out_dur_ff;
   assign rsp.is_mark   = out_mark_ff;
   assign rsp.frame_end = out_end_ff;
   assign rsp.last      = out_last_ff;

   assign out_free  = !out_valid_ff || rsp.ready;
   // restoring divide, one quotient bit per step
   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign take      = (trial >= {1'b0, freq_i});
   assign trial_sub = trial - {1'b0, freq_i};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      mark_in      = mark_ff;
      space_in     = space_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_dur_in   = out_dur_ff;
      out_mark_in  = out_mark_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      pop_o        = 1'b0;
      quot_sat     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid_i) begin
               case (cmd_i.kind)
                  CMD_END: begin
                     if (out_free) begin
                        pop_o        = 1'b1;
                        out_valid_in = 1'b1;
                        out_dur_in   = '0;
                        out_mark_in  = 1'b0;
                        out_end_in   = 1'b1;
                        out_last_in  = 1'b1;
                     end
                  end
                  CMD_MARK, CMD_PAIR: begin
                     pop_o    = 1'b1;
                     kind_in  = cmd_i.kind;
                     dvd_in   = DVD_W'(cmd_i.delta) * DVD_W'(US_PER_S);
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = ST_DIV;
                  end
                  default: begin
                     pop_o = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = take ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], take};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               quot_sat = (|dvd_in[DVD_W-1:DUR_W]) ? '1 : dvd_in[DUR_W-1:0];
               if (kind_ff == CMD_PAIR) begin
                  space_in = quot_sat;
                  state_in = ST_EMIT_MARK;
               end else begin
                  mark_in  = quot_sat;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_MARK: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_dur_in   = mark_ff;
               out_mark_in  = 1'b1;
               out_end_in   = 1'b0;
               out_last_in  = 1'b0;
               state_in     = ST_EMIT_SPACE;
            end
         end
         ST_EMIT_SPACE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_dur_in   = space_ff;
               out_mark_in  = 1'b0;
               out_end_in   = 1'b0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= CMD_MARK;
         step_ff      <= '0;
         mark_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         step_ff      <= step_in;
         mark_ff      <= mark_in;
         out_valid_ff <= out_valid_in;
      end
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      space_ff    <= space_in;
      out_dur_ff  <= out_dur_in;
      out_mark_ff <= out_mark_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

   `IECF_ASSERT_IMPL(a_end_fields, clock, reset, out_valid_ff && out_end_ff,
                     out_dur_ff == '0 && !out_mark_ff && out_last_ff)
   `IECF_ASSERT_NEXT(a_mark_then_space, clock, reset, state_ff == ST_EMIT_MARK && out_free,
                     state_ff == ST_EMIT_SPACE && out_mark_ff && !out_last_ff)

endmodule

// ===== hdl/ir_edge_capture_framer.sv =====
// IR edge framer: req items are either a receiver edge with a free-running timestamp (mode 0)
// or a one-millisecond tick (mode 1); rsp items are mark/space durations in microseconds,
// sent as mark-then-space pairs, plus one frame_end item when a frame of at least one pair
// goes idle for gap_ms ticks. The front end takes one req item per cycle while its two-entry
// command queue has room; ticks that end no frame, first edges and edges past the limit
// finish there. Each edge that closes a duration costs the back end one multiply by 1e6 and
// 52 restoring divide steps by the frequency CSR, one quotient bit per step; a closed pair
// then leaves through the output register as a mark item and then a space item. The back end
// divides one duration at a time. Write the CSRs only while the block is idle.
module ir_edge_capture_framer (
   input  logic                            clock,
   input  logic                            reset,
   iecf_req_if.sink                        req_chan,
   iecf_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [iecf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iecf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import iecf_pkg::*;

   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;

   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    pop;
   cmd_type head_cmd;
   logic    empty;

   always_comb begin
      freq_in = freq_ff;
      gap_in  = gap_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FREQ: freq_in = csr_wdata[FREQ_W-1:0];
            CSR_GAP:  gap_in  = csr_wdata[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
         gap_ff  <= GAP_RESET;
      end else begin
         freq_ff <= freq_in;
         gap_ff  <= gap_in;
      end
   end

   iecf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .gap_ms_i (gap_ff),
      .full_i   (full),
      .push_o   (push),
      .cmd_o    (push_cmd)
   );

   iecf_cmd_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .push_data_i (push_cmd),
      .full_o      (full),
      .pop_i       (pop),
      .head_o      (head_cmd),
      .empty_o     (empty)
   );

   iecf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .freq_i      (freq_ff),
      .cmd_valid_i (!empty),
      .cmd_i       (head_cmd),
      .pop_o       (pop),
      .rsp         (rsp_chan)
   );

endmodule
